// ===== rtl/puct_child_select_table_top_defines.svh =====
// assertion macros for the child selection table
// used by the top level; no other dependencies
`ifndef PUCT_CHILD_SELECT_TABLE_TOP_DEFINES_SVH
`define PUCT_CHILD_SELECT_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PCST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PCST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCST_ASSERT(label, clk, rst_n, prop, msg)
`define PCST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/pcst_pkg.sv =====
// shared types and constants of the child selection table
// no dependencies
`default_nettype none
package pcst_pkg;
	localparam int VISIT_W = 20;
	localparam logic [VISIT_W-1:0] VISIT_MAX = 20'hFFFFF;
	localparam int DIVN_W = 37;
	localparam int DIVD_W = 21;
	localparam int ROOT_W = 10;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_EXPAND = 2'd1,
		FUNC_BACKUP = 2'd2,
		FUNC_SELECT = 2'd3
	} func_t;

	localparam logic [2:0] ADDR_EXPLORE_GAIN = 3'd0;
	localparam logic [15:0] EXPLORE_GAIN_RESET = 16'd4096;

	typedef struct packed {
		logic [1:0]         func;
		logic [15:0]        action_id;
		logic [15:0]        prior;
		logic [5:0]         child_index;
		logic signed [15:0] value;
		logic [19:0]        parent_visits;
	} req_t;

	typedef struct packed {
		logic [5:0]  best_index;
		logic [15:0] best_action;
		logic        leaf;
		logic [6:0]  child_count;
		logic        error;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        action;
		logic [15:0]        prior;
		logic signed [15:0] mean;
		logic [VISIT_W-1:0] visits;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQRT, ST_WALK, ST_MUL, ST_DIVGO, ST_DIV, ST_APPLY, ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/pcst_cell.sv =====
// one cell of the child ring: holds one child entry
// depends on pcst_pkg
`default_nettype none
module pcst_cell (
	input  wire logic            clk,
	input  wire logic            shift,
	input  wire pcst_pkg::entry_t nbr,
	output pcst_pkg::entry_t      ent
);
	pcst_pkg::entry_t ent_q;

	// take the neighbour's entry on each ring step
	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= nbr;
		end
	end

	assign ent = ent_q;
endmodule
`default_nettype wire

// ===== rtl/pcst_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on pcst_pkg
`default_nettype none
module pcst_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pcst_pkg::DIVN_W-1:0] dividend,
	input  wire logic [pcst_pkg::DIVD_W-1:0] divisor,
	output logic                             busy,
	output logic                             done,
	output logic [pcst_pkg::DIVN_W-1:0]      quotient
);
	localparam int CNT_W = $clog2(pcst_pkg::DIVN_W + 1);

	logic [CNT_W-1:0]                cnt_q;
	logic                            done_q;
	logic [pcst_pkg::DIVN_W-1:0]     quo_q;
	logic [pcst_pkg::DIVD_W:0]       rem_q;
	logic [pcst_pkg::DIVD_W-1:0]     dsr_q;
	logic [pcst_pkg::DIVD_W:0]       rem_sh;
	logic                            fits;

	// shift in next dividend bit and trial subtract
	assign rem_sh = {rem_q[pcst_pkg::DIVD_W-1:0], quo_q[pcst_pkg::DIVN_W-1]};
	assign fits = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(pcst_pkg::DIVN_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[pcst_pkg::DIVN_W-2:0], fits};
			rem_q <= fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/pcst_isqrt.sv =====
// serial integer square root of a 20 bit count, two radicand bits per cycle
// depends on pcst_pkg
`default_nettype none
module pcst_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [pcst_pkg::VISIT_W-1:0] radicand,
	output logic                              done,
	output logic [pcst_pkg::ROOT_W-1:0]       root
);
	localparam int W = pcst_pkg::VISIT_W + 2;

	logic [W-1:0] x_q;
	logic [W-1:0] root_q;
	logic [W-1:0] bit_q;
	logic         run_q;
	logic         done_q;
	logic [W-1:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[1:0] != 2'b00) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= W'(radicand);
			root_q <= '0;
			bit_q  <= W'(1) << pcst_pkg::VISIT_W;
		end else if (run_q) begin
			if (x_q >= trial) begin
				x_q    <= x_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[pcst_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/puct_child_select_table_top.sv =====
// child selection table for one search-tree node
// The block takes one request transfer on req (valid/ready) and returns one
// response transfer on rsp (valid/ready); the exploration gain is set over
// the APB-style port at byte address 0.
// Children live in a ring of cells; each ring step moves every entry one cell
// towards the head, and a full turn of MAX_CHILDREN steps brings them home.
// Clear and a rejected item go straight to the response. Expand walks a
// full turn of the ring; backup and select also walk it, working the indexed
// child or every child in the table through the shared serial divider,
// which yields a 37-bit quotient. Select first takes the square root of the
// parent visit count.
// One request is worked at a time; req_ready rises the cycle after the
// response is loaded.
// A finished response waits in the output register while rsp_ready is low;
// the next item is still taken and worked, and its response is held back
// until the register is free.
// Reset empties the table and sets the gain to 1.0; entries are not
// cleared, as an entry is only read once an expand has written it.
// Depends on pcst_pkg, pcst_cell, pcst_div, pcst_isqrt and the defines header.
`default_nettype none
`include "puct_child_select_table_top_defines.svh"
module puct_child_select_table_top #(
	parameter int MAX_CHILDREN = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire pcst_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output pcst_pkg::rsp_t      rsp,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [2:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int POS_W = (MAX_CHILDREN > 2) ? $clog2(MAX_CHILDREN) : 1;
	localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_CHILDREN - 1);

	pcst_pkg::state_t state_q, state_nxt;
	logic [15:0]         gain_q;
	logic [CNT_W-1:0]    count_q, count_nxt;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    idx_q;
	logic [POS_W-1:0]    bi_q;
	logic [15:0]         ba_q;
	logic signed [31:0]  best_q;
	pcst_pkg::func_t     func_q;
	logic [15:0]         act_q;
	logic [15:0]         prior_q;
	logic signed [15:0]  value_q;
	logic                err_q;
	logic [25:0]         cps_q;
	logic [pcst_pkg::DIVN_W-1:0] dvn_q;
	logic [pcst_pkg::DIVD_W-1:0] dvd_q;
	logic                neg_q;
	pcst_pkg::rsp_t      rsp_q;
	logic                rsp_valid_q;

	pcst_pkg::entry_t ent [MAX_CHILDREN];
	pcst_pkg::entry_t head, wb;
	logic             rot, need_work, req_take, rsp_load;
	logic             sq_start, sq_done, div_start, div_busy, div_done;
	logic [pcst_pkg::ROOT_W-1:0] sq_root;
	logic [pcst_pkg::DIVN_W-1:0] quo;
	logic signed [37:0]  num;
	logic [36:0]         mag;
	logic [41:0]         prod;
	logic signed [31:0]  score;
	logic [pcst_pkg::DIVD_W-1:0] den;
	logic                err_in;
	pcst_pkg::func_t     func_in;

	// ring of cells; the head hands its entry, possibly updated, to the tail
	assign head = ent[0];
	for (genvar i = 0; i < MAX_CHILDREN; i++) begin : g_ring
		pcst_cell u_cell (
			.clk  (clk),
			.shift(rot),
			.nbr  ((i == MAX_CHILDREN - 1) ? wb : ent[(i + 1) % MAX_CHILDREN]),
			.ent  (ent[i])
		);
	end

	pcst_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(req.parent_visits),
		.done    (sq_done),
		.root    (sq_root)
	);

	pcst_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dvn_q),
		.divisor (dvd_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quo)
	);

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == pcst_pkg::ADDR_EXPLORE_GAIN) ? {16'd0, gain_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= pcst_pkg::EXPLORE_GAIN_RESET;
		end else if (psel && penable && pwrite && paddr == pcst_pkg::ADDR_EXPLORE_GAIN) begin
			gain_q <= pwdata[15:0];
		end
	end

	// request decode
	assign req_ready = state_q == pcst_pkg::ST_IDLE;
	assign req_take = req_valid && req_ready;
	assign func_in = pcst_pkg::func_t'(req.func);
	always_comb begin
		case (func_in)
			pcst_pkg::FUNC_EXPAND: err_in = count_q == CNT_W'(MAX_CHILDREN);
			pcst_pkg::FUNC_BACKUP: err_in = CMP_W'(req.child_index) >= CMP_W'(count_q);
			default:               err_in = 1'b0;
		endcase
	end

	// work at the head of the ring
	assign need_work = (func_q == pcst_pkg::FUNC_BACKUP && pos_q == idx_q && !err_q) ||
		(func_q == pcst_pkg::FUNC_SELECT && CNT_W'(pos_q) < count_q);
	assign den = pcst_pkg::DIVD_W'(head.visits) + 1'b1;
	assign num = 38'(head.mean) * $signed({18'd0, head.visits}) + 38'(value_q);
	assign mag = num[37] ? 37'(-num) : 37'(num);
	assign prod = 42'(cps_q) * 42'(head.prior);
	assign score = 32'(head.mean) + $signed({3'd0, quo[28:0]});
	assign rsp_load = state_q == pcst_pkg::ST_DONE && (!rsp_valid_q || rsp_ready);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pcst_pkg::ST_IDLE: begin
				if (req_take) begin
					if (func_in == pcst_pkg::FUNC_CLEAR || err_in) begin
						state_nxt = pcst_pkg::ST_DONE;
					end else if (func_in == pcst_pkg::FUNC_SELECT) begin
						state_nxt = pcst_pkg::ST_SQRT;
					end else begin
						state_nxt = pcst_pkg::ST_WALK;
					end
				end
			end
			pcst_pkg::ST_SQRT: if (sq_done) state_nxt = pcst_pkg::ST_WALK;
			pcst_pkg::ST_WALK: begin
				if (need_work) begin
					state_nxt = pcst_pkg::ST_MUL;
				end else if (pos_q == LAST_POS) begin
					state_nxt = pcst_pkg::ST_DONE;
				end
			end
			pcst_pkg::ST_MUL:   state_nxt = pcst_pkg::ST_DIVGO;
			pcst_pkg::ST_DIVGO: state_nxt = pcst_pkg::ST_DIV;
			pcst_pkg::ST_DIV:   if (div_done) state_nxt = pcst_pkg::ST_APPLY;
			pcst_pkg::ST_APPLY: begin
				state_nxt = (pos_q == LAST_POS) ? pcst_pkg::ST_DONE : pcst_pkg::ST_WALK;
			end
			pcst_pkg::ST_DONE:  if (rsp_load) state_nxt = pcst_pkg::ST_IDLE;
			default:            state_nxt = pcst_pkg::ST_IDLE;
		endcase
	end

	// control outputs and write-back entry
	always_comb begin
		rot = 1'b0;
		wb = head;
		sq_start = req_take && func_in == pcst_pkg::FUNC_SELECT;
		div_start = state_q == pcst_pkg::ST_DIVGO;
		case (state_q)
			pcst_pkg::ST_WALK: begin
				rot = !need_work;
				if (func_q == pcst_pkg::FUNC_EXPAND && CNT_W'(pos_q) == count_q) begin
					wb.action = act_q;
					wb.prior  = prior_q;
					wb.mean   = '0;
					wb.visits = '0;
				end
			end
			pcst_pkg::ST_APPLY: begin
				rot = 1'b1;
				if (func_q == pcst_pkg::FUNC_BACKUP) begin
					wb.mean = neg_q ? -$signed(quo[15:0]) : $signed(quo[15:0]);
					if (head.visits != pcst_pkg::VISIT_MAX) begin
						wb.visits = head.visits + 1'b1;
					end
				end
			end
			default: rot = 1'b0;
		endcase
	end

	// table size after the item
	always_comb begin
		count_nxt = count_q;
		if (func_q == pcst_pkg::FUNC_CLEAR) begin
			count_nxt = '0;
		end else if (func_q == pcst_pkg::FUNC_EXPAND && !err_q) begin
			count_nxt = count_q + 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcst_pkg::ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (rot) begin
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
			end
			if (rsp_load) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_take) begin
			func_q  <= func_in;
			act_q   <= req.action_id;
			prior_q <= req.prior;
			value_q <= req.value;
			idx_q   <= POS_W'(req.child_index);
			err_q   <= err_in;
			bi_q    <= '0;
			ba_q    <= '0;
			best_q  <= '0;
		end
		if (sq_done) begin
			cps_q <= 26'(gain_q) * 26'(sq_root);
		end
		if (state_q == pcst_pkg::ST_MUL) begin
			dvd_q <= den;
			if (func_q == pcst_pkg::FUNC_BACKUP) begin
				dvn_q <= mag + 37'(den >> 1);
				neg_q <= num[37];
			end else begin
				dvn_q <= 37'(prod[41:13]);
				neg_q <= 1'b0;
			end
		end
		if (state_q == pcst_pkg::ST_APPLY && func_q == pcst_pkg::FUNC_SELECT) begin
			if (pos_q == '0 || score > best_q) begin
				best_q <= score;
				bi_q   <= pos_q;
				ba_q   <= head.action;
			end
		end
		if (rsp_load) begin
			rsp_q.best_index  <= 6'(bi_q);
			rsp_q.best_action <= ba_q;
			rsp_q.leaf        <= count_nxt == '0;
			rsp_q.child_count <= 7'(count_nxt);
			rsp_q.error       <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`PCST_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_CHILDREN), "count above table size")
	`PCST_ASSERT(a_idle_home, clk, arst_n, !req_ready || pos_q == '0, "ring not home when idle")
	`PCST_ASSERT(a_div_quiet, clk, arst_n, !req_ready || !div_busy, "divider busy between items")
	`PCST_ASSERT_NEXT(a_load_valid, clk, arst_n, rsp_load, rsp_valid, "response lost on load")
endmodule
`default_nettype wire
